/* sv/prc_pkg.sv */
`timescale 1ns / 1ps

package prc_pkg;

    // Q16.16 data word
    typedef logic signed [31:0] t_q16;
    // Q8.8 / Q1.15 coefficient
    typedef logic signed [15:0] t_coef;

    localparam int unsigned AXIS_W  = 2;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned SCHED_W = 16;

    // gains registers on the APB port, 64 bits each at 8-byte stride
    localparam int unsigned NUM_REGS = 3;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 64;

    // packed layout of one gains register
    typedef struct packed {
        t_coef alpha;
        t_coef kd;
        t_coef ki;
        t_coef kp;
    } t_gains;

    // per-axis loop state held in the state RAM
    typedef struct packed {
        t_q16 integ;
        t_q16 prev;
        t_q16 fd;
    } t_axis_state;

    // saturate to the signed 32-bit range
    function automatic t_q16 sat32(input logic signed [63:0] v);
        t_q16 res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

/* sv/prc_ifs.sv */
`timescale 1ns / 1ps

// sample word into the controller
interface prc_in_if;
    import prc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [AXIS_W-1:0]        axis_sel;
    t_q16                     target;
    t_q16                     measured;
    logic [LIMIT_W-1:0]       limit;
    logic [SCHED_W-1:0]       sched_gain;
    t_q16                     feedforward;

    modport source (
        output valid, axis_sel, target, measured, limit, sched_gain, feedforward,
        input  ready
    );
    modport sink (
        input  valid, axis_sel, target, measured, limit, sched_gain, feedforward,
        output ready
    );
endinterface

// drive word out of the controller
interface prc_out_if;
    import prc_pkg::*;

    logic valid;
    logic ready;
    t_q16 drive;

    modport source (
        output valid, drive,
        input  ready
    );
    modport sink (
        input  valid, drive,
        output ready
    );
endinterface

/* sv/prc_ram.sv */
`timescale 1ns / 1ps

module prc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/prc_mul.sv */
`timescale 1ns / 1ps

module prc_mul (
    input  logic               i_clk,
    input  logic signed [34:0] i_a,
    input  logic signed [16:0] i_b,
    output logic signed [51:0] o_prod
);

    logic signed [51:0] r_prod;

    // one signed product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_prod <= 52'(i_a) * 52'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* sv/pid_rate_controller_unit.sv */
`timescale 1ns / 1ps
// Sequence: an accepted word runs from LOAD to DEC, then waits in OUT for a free output
//   register; a word for an axis outside the configured count goes straight to OUT with
//   drive 0. A new word is taken only in IDLE, after the eight passes through the shared
//   35x17 multiplier and the read-modify-write of the per-axis state RAM.
// Reset: synchronous, active low; clears the sequencer, the output valid flag, the gains
//   registers and the per-axis valid bits, so every axis state reads as zero.
module pid_rate_controller_unit #(
    parameter int unsigned AXES = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    prc_in_if.sink                         i_in,
    prc_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prc_pkg::PADDR_W-1:0]    paddr,
    input  logic [prc_pkg::PDATA_W-1:0]    pwdata,
    output logic [prc_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import prc_pkg::*;

    localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int unsigned SW = $bits(t_axis_state);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_FILT = 4'd2;
    localparam logic [3:0] S_FSAT = 4'd3;
    localparam logic [3:0] S_DMUL = 4'd4;
    localparam logic [3:0] S_PD   = 4'd5;
    localparam logic [3:0] S_IHI  = 4'd6;
    localparam logic [3:0] S_ILO  = 4'd7;
    localparam logic [3:0] S_PHI  = 4'd8;
    localparam logic [3:0] S_PLO  = 4'd9;
    localparam logic [3:0] S_SUM  = 4'd10;
    localparam logic [3:0] S_DEC  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]          r_state, n_state;
    logic                r_out_valid, n_out_valid;
    t_q16                r_drive;
    logic [AXES-1:0]     r_valid;
    logic [PDATA_W-1:0]  r_gain [NUM_REGS];

    // latched sample
    logic [AW-1:0]       r_axis;
    logic                r_bad;
    logic signed [32:0]  r_err;
    t_q16                r_meas;
    logic [LIMIT_W-1:0]  r_lim;
    logic [SCHED_W-1:0]  r_sg;
    t_q16                r_ff;
    t_gains              r_g;

    // working registers
    t_q16                r_integ;
    t_q16                r_fd;
    logic signed [33:0]  r_dd;
    logic signed [40:0]  r_pterm;
    logic signed [40:0]  r_inc0;
    logic signed [41:0]  r_pd;
    logic signed [59:0]  r_acc;
    logic signed [49:0]  r_inc;
    logic signed [50:0]  r_pdsum;
    logic signed [52:0]  r_outv;
    logic signed [53:0]  r_outf;

    logic                w_accept;
    logic                w_axis_ok;
    logic [1:0]          w_widx;
    logic                w_cfg_we;
    t_gains              w_gsel;
    logic [SW-1:0]       w_rdata;
    t_axis_state         w_rd;
    t_axis_state         w_st;
    t_axis_state         w_wr;
    logic                w_we;
    logic signed [34:0]  w_ma;
    logic signed [16:0]  w_mb;
    logic signed [51:0]  w_prod;
    logic signed [35:0]  w_fsum;
    logic signed [53:0]  w_lim_p;
    logic signed [53:0]  w_lim_n;
    logic                w_err_neg;
    logic                w_err_pos;
    logic                w_cond;
    t_q16                w_clamp;

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_axis_ok = 32'(i_in.axis_sel) < AXES;

    // ------------------------------------------------------------------
    // APB gains registers
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_widx   = paddr[4:3];
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_gain[i] <= '0;
            end
        end else if (w_cfg_we && (32'(w_widx) < NUM_REGS) && (32'(w_widx) < AXES)) begin
            r_gain[w_widx] <= pwdata;
        end
    end

    assign prdata = (32'(w_widx) < NUM_REGS) ? r_gain[w_widx] : '0;

    // pick the gains of the incoming axis; axes without a register keep zero gains
    assign w_gsel = (32'(i_in.axis_sel) < NUM_REGS) ? t_gains'(r_gain[i_in.axis_sel]) : '0;

    // ------------------------------------------------------------------
    // per-axis state RAM
    // ------------------------------------------------------------------
    prc_ram #(
        .WIDTH (SW),
        .DEPTH (AXES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_axis),
        .i_wdata (w_wr),
        .i_raddr (AW'(i_in.axis_sel)),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_axis_state'(w_rdata);
    // an entry never written reads as zero
    assign w_st = r_valid[r_axis] ? w_rd : '0;

    // ------------------------------------------------------------------
    // shared multiplier operand select
    // ------------------------------------------------------------------
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_LOAD: begin
                w_ma = 35'(r_err);
                w_mb = 17'(r_g.kp);
            end
            S_FILT: begin
                w_ma = 35'(r_dd);
                w_mb = 17'(r_g.alpha);
            end
            S_FSAT: begin
                w_ma = 35'(r_err);
                w_mb = 17'(r_g.ki);
            end
            S_DMUL: begin
                w_ma = 35'(r_fd);
                w_mb = 17'(r_g.kd);
            end
            S_PD: begin
                w_ma = 35'($signed(r_inc0[40:16]));
                w_mb = {1'b0, r_sg};
            end
            S_IHI: begin
                w_ma = {19'b0, r_inc0[15:0]};
                w_mb = {1'b0, r_sg};
            end
            S_ILO: begin
                w_ma = 35'($signed(r_pd[41:16]));
                w_mb = {1'b0, r_sg};
            end
            S_PHI: begin
                w_ma = {19'b0, r_pd[15:0]};
                w_mb = {1'b0, r_sg};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    prc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // ------------------------------------------------------------------
    // decision and clamp logic
    // ------------------------------------------------------------------
    assign w_fsum    = 36'(r_fd) + 36'(w_prod >>> 15);
    assign w_lim_p   = 54'(signed'({1'b0, r_lim}));
    assign w_lim_n   = -w_lim_p;
    assign w_err_neg = r_err[32];
    assign w_err_pos = !r_err[32] && (r_err != '0);
    assign w_cond    = ((54'(r_outv) <= w_lim_p) && (54'(r_outv) >= w_lim_n)) ||
                       ((54'(r_outv) > w_lim_p) && w_err_neg) ||
                       ((54'(r_outv) < w_lim_n) && w_err_pos);

    // write back the new axis state in the decision step
    assign w_we        = (r_state == S_DEC);
    assign w_wr.integ  = w_cond ? sat32(64'(r_integ) + 64'(r_inc)) : r_integ;
    assign w_wr.prev   = r_meas;
    assign w_wr.fd     = r_fd;

    always_comb begin
        if (r_bad) begin
            w_clamp = '0;
        end else if (r_outf > w_lim_p) begin
            w_clamp = w_lim_p[31:0];
        end else if (r_outf < w_lim_n) begin
            w_clamp = w_lim_n[31:0];
        end else begin
            w_clamp = r_outf[31:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_axis_ok ? S_LOAD : S_OUT;
                end
            end
            S_LOAD:  n_state = S_FILT;
            S_FILT:  n_state = S_FSAT;
            S_FSAT:  n_state = S_DMUL;
            S_DMUL:  n_state = S_PD;
            S_PD:    n_state = S_IHI;
            S_IHI:   n_state = S_ILO;
            S_ILO:   n_state = S_PHI;
            S_PHI:   n_state = S_PLO;
            S_PLO:   n_state = S_SUM;
            S_SUM:   n_state = S_DEC;
            S_DEC:   n_state = S_OUT;
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_we) begin
                r_valid[r_axis] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_axis <= AW'(i_in.axis_sel);
                    r_bad  <= !w_axis_ok;
                    r_err  <= 33'(i_in.target) - 33'(i_in.measured);
                    r_meas <= i_in.measured;
                    r_lim  <= i_in.limit;
                    r_sg   <= i_in.sched_gain;
                    r_ff   <= i_in.feedforward;
                    r_g    <= w_gsel;
                end
            end
            S_LOAD: begin
                r_integ <= w_st.integ;
                r_fd    <= w_st.fd;
                r_dd    <= 34'(r_meas) - 34'(w_st.prev) - 34'(w_st.fd);
            end
            S_FILT: begin
                r_pterm <= 41'(w_prod >>> 8);
            end
            S_FSAT: begin
                // freeze the filter while the D gain is zero
                if (r_g.kd != '0) begin
                    r_fd <= sat32(64'(w_fsum));
                end
            end
            S_DMUL: begin
                r_inc0 <= 41'(w_prod >>> 8);
            end
            S_PD: begin
                r_pd <= 42'(r_pterm) - 42'(w_prod >>> 8);
            end
            S_IHI: begin
                r_acc <= 60'(w_prod) <<< 16;
            end
            S_ILO: begin
                r_inc <= 50'((r_acc + 60'(w_prod)) >>> 8);
            end
            S_PHI: begin
                r_acc <= 60'(w_prod) <<< 16;
            end
            S_PLO: begin
                r_pdsum <= 51'((r_acc + 60'(w_prod)) >>> 8);
            end
            S_SUM: begin
                r_outv <= 53'(r_pdsum) + 53'(r_integ) + 53'(r_ff);
            end
            S_DEC: begin
                r_outf <= w_cond ? (54'(r_outv) + 54'(r_inc)) : 54'(r_outv);
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    r_drive <= w_clamp;
                end
            end
            default: begin
                r_drive <= r_drive;
            end
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;

endmodule

/* sv/prc_checker.sv */
`timescale 1ns / 1ps

module prc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_drive,
    input logic        i_pready
);

    // after reset the block is empty and ready for a word
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("output valid or input stalled after reset");

    // one word at a time: an accepted word stalls the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken again straight after a word");

    // a waiting drive word holds its value
    a_drive_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_drive)))
        else $error("drive word dropped or changed while stalled");

    // the register port never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind pid_rate_controller_unit prc_checker u_prc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive     (o_out.drive),
    .i_pready    (pready)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import prc_pkg::*;

    localparam int      N_AXES        = 3;
    localparam int      REG_STRIDE    = 8;
    localparam int      SETTLE_CYCLES = 16;
    localparam int      TAIL_CYCLES   = 20;
    localparam int      CYCLE_LIMIT   = 400000;
    localparam int      RAND_PHASES   = 6;
    localparam int      PHASE_WORDS   = 165;
    localparam int      PRESSURE_HOLD = 400;
    localparam int      PRESSURE_RUN  = 40;
    localparam int      PATTERN_SPAN  = 64;
    localparam int      MAX_REPORTS   = 10;

    localparam t_q16    Q_MAX   = 32'sh7FFF_FFFF;
    localparam t_q16    Q_MIN   = 32'sh8000_0000;
    localparam t_q16    Q_ONE   = 32'sh0001_0000;
    localparam t_q16    Q_FOUR  = 32'sh0004_0000;
    localparam t_q16    Q_BIG   = 32'sh0010_0000;
    localparam logic [LIMIT_W-1:0] LIM_MAX = 31'h7FFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIM_ONE = 31'h0001_0000;
    localparam logic [SCHED_W-1:0] SG_MAX  = 16'hFFFF;
    localparam logic [SCHED_W-1:0] SG_ONE  = 16'h0100;

    // alpha 0.5, D 0.25, I 0.5, P 1.0
    localparam t_gains G_TYPICAL = 64'h4000_0040_0080_0100;
    localparam t_gains G_MAX     = 64'h7FFF_7FFF_7FFF_7FFF;
    localparam t_gains G_MIN     = 64'h8000_8000_8000_8000;
    localparam t_gains G_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_gains G_ZERO    = 64'h0;
    localparam t_gains G_MIXED   = 64'h5A5A_A5A5_0F0F_F0F0;
    // integral only, D frozen
    localparam t_gains G_I_ONLY  = 64'h4000_0000_7FFF_0000;
    // integral plus D 1.0, fastest filter
    localparam t_gains G_I_D     = 64'h7FFF_0100_7FFF_0000;

    typedef enum int {GAINS_TYPICAL, GAINS_EXTREME, GAINS_ANY} t_gains_mode;

    typedef struct packed {
        logic [AXIS_W-1:0]  axis_sel;
        t_q16               target;
        t_q16               measured;
        logic [LIMIT_W-1:0] limit;
        logic [SCHED_W-1:0] sched_gain;
        t_q16               feedforward;
    } t_sample;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    prc_in_if  in_if ();
    prc_out_if out_if ();

    pid_rate_controller_unit #(
        .AXES    (N_AXES)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // loop state mirrored per axis
    t_gains axis_gains [N_AXES];
    t_q16   integ_acc  [N_AXES];
    t_q16   last_meas  [N_AXES];
    t_q16   filt_delta [N_AXES];

    t_q16   drive_q[$];

    int     setpoint  [N_AXES];
    int     walk_meas [N_AXES];

    int     n_mismatch;
    int     n_checked;
    int     n_sent;
    int     n_off_axis;
    int     n_reg_writes;
    int     cycle_count;
    int     burst_left;
    int     hold_off_left;
    bit     rx_stalls_on;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d drive words outstanding",
                 cycle_count, drive_q.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %h, got %h", $time, what, want_v, got_v);
        end
    endtask

    function automatic t_q16 clip32(input longint v);
        if (v > longint'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < longint'(Q_MIN)) begin
            return Q_MIN;
        end
        return t_q16'(v);
    endfunction

    // advance the mirrored loop state by one sample and return its drive word
    function automatic t_q16 compute_drive(input t_sample s);
        t_gains g;
        longint kp, ki, kd, alpha, err, lim, sg, pterm, dterm, step, inc, outv;
        int     a;
        if (s.axis_sel >= N_AXES) begin
            return '0;
        end
        a     = int'(s.axis_sel);
        g     = axis_gains[a];
        kp    = longint'($signed(g.kp));
        ki    = longint'($signed(g.ki));
        kd    = longint'($signed(g.kd));
        alpha = longint'($signed(g.alpha));
        err   = longint'($signed(s.target)) - longint'($signed(s.measured));
        lim   = longint'(s.limit);
        sg    = longint'(s.sched_gain);
        pterm = (kp * err) >>> 8;
        dterm = 0;
        // filter on measurement change, held while D is zero
        if (kd != 0) begin
            step = ((longint'($signed(s.measured)) - longint'(last_meas[a])
                     - longint'(filt_delta[a])) * alpha) >>> 15;
            filt_delta[a] = clip32(longint'(filt_delta[a]) + step);
            dterm = -((longint'(filt_delta[a]) * kd) >>> 8);
        end
        last_meas[a] = s.measured;
        outv = (((pterm + dterm) * sg) >>> 8) + longint'(integ_acc[a])
               + longint'($signed(s.feedforward));
        // integrate only inside the limit or when the error pulls back
        if ((outv <= lim && outv >= -lim) || (outv > lim && err < 0)
                || (outv < -lim && err > 0)) begin
            inc = (((err * ki) >>> 8) * sg) >>> 8;
            integ_acc[a] = clip32(longint'(integ_acc[a]) + inc);
            outv += inc;
        end
        if (outv > lim) begin
            outv = lim;
        end else if (outv < -lim) begin
            outv = -lim;
        end
        return t_q16'(outv);
    endfunction

    function automatic t_sample sample_of(input int unsigned axis, input t_q16 tgt,
                                          input t_q16 meas, input logic [LIMIT_W-1:0] lim,
                                          input logic [SCHED_W-1:0] sg, input t_q16 ff);
        t_sample s;
        s.axis_sel    = AXIS_W'(axis);
        s.target      = tgt;
        s.measured    = meas;
        s.limit       = lim;
        s.sched_gain  = sg;
        s.feedforward = ff;
        return s;
    endfunction

    function automatic int signed_span(input int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    function automatic t_gains random_gains(input t_gains_mode mode);
        t_gains g;
        t_coef  picks [5];
        picks = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
        case (mode)
            GAINS_TYPICAL: begin
                g.kp    = t_coef'(signed_span(1024));
                g.ki    = t_coef'(signed_span(256));
                g.kd    = ($urandom_range(0, 3) == 0) ? '0 : t_coef'(signed_span(1024));
                g.alpha = t_coef'($urandom_range(0, 32767));
            end
            GAINS_EXTREME: begin
                g.kp    = picks[$urandom_range(0, 4)];
                g.ki    = picks[$urandom_range(0, 4)];
                g.kd    = picks[$urandom_range(0, 4)];
                g.alpha = picks[$urandom_range(0, 4)];
            end
            default: begin
                g = {$urandom, $urandom};
            end
        endcase
        return g;
    endfunction

    // mostly a slowly moving plant around a setpoint, some raw noise
    function automatic t_sample random_sample();
        t_sample s;
        int      a;
        if ($urandom_range(0, 9) == 0) begin
            s.axis_sel = AXIS_W'(N_AXES);
        end else begin
            s.axis_sel = AXIS_W'($urandom_range(0, N_AXES - 1));
        end
        if ($urandom_range(0, 3) == 0) begin
            s.target      = $urandom;
            s.measured    = $urandom;
            s.limit       = LIMIT_W'($urandom);
            s.sched_gain  = SCHED_W'($urandom);
            s.feedforward = $urandom;
        end else begin
            a = (s.axis_sel < N_AXES) ? int'(s.axis_sel) : 0;
            walk_meas[a] = walk_meas[a] + signed_span(1 << 14);
            if (walk_meas[a] > (1 << 24) || walk_meas[a] < -(1 << 24)) begin
                walk_meas[a] = setpoint[a];
            end
            s.measured    = walk_meas[a];
            s.target      = setpoint[a] + signed_span(1 << 12);
            s.limit       = LIMIT_W'($urandom_range(0, 1 << 22));
            s.sched_gain  = SCHED_W'($urandom_range(0, 1024));
            s.feedforward = signed_span(1 << 18);
        end
        return s;
    endfunction

    // offer one word and wait for the block to take it
    task automatic send_sample(input t_sample s);
        in_if.valid       <= 1'b1;
        in_if.axis_sel    <= s.axis_sel;
        in_if.target      <= s.target;
        in_if.measured    <= s.measured;
        in_if.limit       <= s.limit;
        in_if.sched_gain  <= s.sched_gain;
        in_if.feedforward <= s.feedforward;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        drive_q.push_back(compute_drive(s));
        n_sent++;
        if (s.axis_sel >= N_AXES) begin
            n_off_axis++;
        end
    endtask

    // drop valid for a random gap at the end of each burst
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // wait until every drive word is back and the block has settled
    task automatic drain();
        in_if.valid <= 1'b0;
        while (drive_q.size() != 0 || hold_off_left != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit is_write, input int idx, input t_gains data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= PADDR_W'(idx * REG_STRIDE);
        pwdata  <= is_write ? data : '0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (is_write) begin
            axis_gains[idx] = data;
            n_reg_writes++;
        end else if (prdata !== data) begin
            note_mismatch("gains readback", data, prdata);
        end
    endtask

    // write all gains registers back to back, then read each one back
    task automatic load_gains(input t_gains g0, input t_gains g1, input t_gains g2);
        t_gains want [N_AXES];
        want = '{g0, g1, g2};
        for (int r = 0; r < N_AXES; r++) begin
            apb_access(1'b1, r, want[r]);
        end
        for (int r = 0; r < N_AXES; r++) begin
            apb_access(1'b0, r, want[r]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // leave the bus idle before returning
        @(posedge clk);
    endtask

    // receive drive words: check against the oldest prediction, then pick next ready
    initial begin : drive_sink
        t_q16        want;
        int          pattern_age;
        logic [15:0] rx_pattern;
        pattern_age = 0;
        rx_pattern  = 16'hFFFF;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (drive_q.size() == 0) begin
                    note_mismatch("drive word with nothing outstanding", '0,
                                  64'(out_if.drive));
                end else begin
                    want = drive_q.pop_front();
                    n_checked++;
                    if (out_if.drive !== want) begin
                        note_mismatch("drive", 64'(want), 64'(out_if.drive));
                    end
                end
            end
            if (pattern_age == 0) begin
                pattern_age = PATTERN_SPAN;
                rx_pattern  = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                              : 16'($urandom | $urandom);
            end
            pattern_age--;
            if (hold_off_left > 0) begin
                hold_off_left--;
                out_if.ready <= 1'b0;
            end else if (!rx_stalls_on) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            end
        end
    end

    // zero gains after reset: drive is feedforward alone, clamped
    task automatic test_reset_state();
        send_sample(sample_of(0, Q_ONE, 0, LIM_MAX, SG_ONE, Q_ONE));
        send_sample(sample_of(1, Q_MAX, Q_MIN, 31'h100, SG_MAX, Q_MIN));
        send_sample(sample_of(N_AXES, Q_MAX, Q_MIN, LIM_MAX, SG_MAX, Q_MAX));
        drain();
    endtask

    // every bit of every gains register both ways, with readback
    task automatic test_gain_registers();
        load_gains(G_ONES, G_ZERO, G_MIXED);
        load_gains(G_ZERO, G_ONES, ~G_MIXED);
    endtask

    task automatic test_extreme_samples();
        load_gains(G_TYPICAL, G_MAX, G_MIN);
        send_sample(sample_of(0, 0, 0, 0, 0, 0));
        send_sample(sample_of(0, Q_MAX, Q_MIN, LIM_MAX, SG_MAX, Q_MAX));
        send_sample(sample_of(0, Q_MIN, Q_MAX, LIM_MAX, SG_MAX, Q_MIN));
        send_sample(sample_of(1, Q_MAX, Q_MIN, LIM_MAX, SG_MAX, 0));
        send_sample(sample_of(1, Q_MIN, Q_MAX, LIM_MAX, SG_MAX, 0));
        send_sample(sample_of(2, Q_MAX, Q_MIN, LIM_MAX, SG_MAX, Q_MAX));
        send_sample(sample_of(2, Q_MIN, Q_MAX, LIM_MAX, SG_MAX, Q_MIN));
        // axis select beyond the configured count
        send_sample(sample_of(N_AXES, Q_MAX, Q_MIN, LIM_MAX, SG_MAX, Q_MAX));
        // zero limit forces zero drive
        send_sample(sample_of(1, Q_ONE, 0, 0, SG_ONE, Q_ONE));
        // above the limit, error pulling back: integrate
        send_sample(sample_of(0, 0, Q_FOUR, LIM_ONE, SG_ONE, Q_BIG));
        // below the limit, error pulling back: integrate
        send_sample(sample_of(0, Q_FOUR, 0, LIM_ONE, SG_ONE, -Q_BIG));
        // above the limit, error pushing further: hold the integrator
        send_sample(sample_of(0, Q_FOUR, 0, LIM_ONE, SG_ONE, Q_BIG));
        send_sample(sample_of(0, Q_ONE, Q_ONE, LIM_MAX, 0, 32'sh0000_1234));
        send_sample(sample_of(2, 0, 1, LIM_MAX, 16'h0001, 0));
        drain();
    endtask

    // drive the integrator into both rails with D frozen, then wake the filter
    task automatic test_integrator_saturation();
        load_gains(G_TYPICAL, G_MAX, G_I_ONLY);
        send_sample(sample_of(2, Q_MAX, Q_MIN, LIM_MAX, SG_MAX, 0));
        send_sample(sample_of(2, Q_MAX, Q_MIN, LIM_MAX, SG_MAX, 0));
        send_sample(sample_of(2, Q_MIN, Q_MAX, LIM_MAX, SG_MAX, 0));
        send_sample(sample_of(2, Q_MIN, Q_MAX, LIM_MAX, SG_MAX, 0));
        send_sample(sample_of(2, Q_MIN, Q_MAX, LIM_MAX, SG_MAX, 0));
        drain();
        load_gains(G_TYPICAL, G_MAX, G_I_D);
        send_sample(sample_of(2, 0, 32'sh0100_0000, LIM_MAX, SG_ONE, 0));
        send_sample(sample_of(2, 0, Q_MIN, LIM_MAX, SG_ONE, 0));
        send_sample(sample_of(2, 0, 0, LIM_MAX, SG_ONE, 0));
        drain();
    endtask

    // random phases, each with fresh gains and its own idling
    task automatic test_random_phases();
        t_gains_mode mode;
        bit          gaps_on;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                1:       mode = GAINS_EXTREME;
                2:       mode = GAINS_ANY;
                default: mode = GAINS_TYPICAL;
            endcase
            if (p == RAND_PHASES - 1) begin
                load_gains(random_gains(t_gains_mode'($urandom_range(0, 2))),
                           random_gains(t_gains_mode'($urandom_range(0, 2))),
                           random_gains(t_gains_mode'($urandom_range(0, 2))));
            end else begin
                load_gains(random_gains(mode), random_gains(mode), random_gains(mode));
            end
            for (int a = 0; a < N_AXES; a++) begin
                setpoint[a]  = signed_span(1 << 22);
                walk_meas[a] = setpoint[a] + signed_span(1 << 16);
            end
            // one phase runs flat out on both sides
            gaps_on      = (p != 4);
            rx_stalls_on = (p != 4);
            // one phase opens with a long receiver hold-off against a busy sender
            if (p == 3) begin
                hold_off_left = PRESSURE_HOLD;
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                send_sample(random_sample());
                if (gaps_on && !(p == 3 && k < PRESSURE_RUN)) begin
                    pace_sender();
                end
            end
            drain();
        end
    endtask

    initial begin : run_tests
        n_mismatch    = 0;
        n_checked     = 0;
        n_sent        = 0;
        n_off_axis    = 0;
        n_reg_writes  = 0;
        burst_left    = 0;
        hold_off_left = 0;
        rx_stalls_on  = 1'b1;
        for (int a = 0; a < N_AXES; a++) begin
            axis_gains[a] = '0;
            integ_acc[a]  = '0;
            last_meas[a]  = '0;
            filt_delta[a] = '0;
            setpoint[a]   = 0;
            walk_meas[a]  = 0;
        end
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_if.valid       <= 1'b0;
        in_if.axis_sel    <= '0;
        in_if.target      <= '0;
        in_if.measured    <= '0;
        in_if.limit       <= '0;
        in_if.sched_gain  <= '0;
        in_if.feedforward <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_gain_registers();
        test_extreme_samples();
        test_integrator_saturation();
        test_random_phases();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d samples over %0d axes (%0d with an unused axis select), %0d gains writes",
                 n_sent, N_AXES, n_off_axis, n_reg_writes);
        $display("Checked %0d drive words in %0d cycles, %0d mismatches",
                 n_checked, cycle_count, n_mismatch);
        if (n_mismatch == 0 && drive_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
sv/prc_pkg.sv
sv/prc_ifs.sv
sv/prc_ram.sv
sv/prc_mul.sv
sv/pid_rate_controller_unit.sv
sv/prc_checker.sv
tb/tb_top.sv
